// ===== rtl/bzs_pkg.sv =====
// Shared types, constants and helper functions of the Bayer zone shading statistics block.
`default_nettype none
package bzs_pkg;

  localparam int GRID           = 5;
  localparam int NZONES         = GRID * GRID;
  localparam int CENTER         = (GRID / 2) * GRID + GRID / 2;
  localparam int PIX_W          = 10;
  localparam int DIM_W          = 13;
  localparam int ZDIM_W         = 11;
  localparam int HALF_W         = 10;
  localparam int CNT_W          = 20;
  localparam int SUM_W          = 32;
  localparam int NUM_W          = 41;
  localparam int MEM_DEPTH      = NZONES * 4;
  localparam int MEM_AW         = 7;
  localparam int ZONE_W         = 5;
  localparam int LUMA_FRAC_BITS = 4;
  localparam int LUMA_SHIFT     = 24 - LUMA_FRAC_BITS;
  localparam int LUMA_W         = 16;
  localparam int V_W            = 19;
  localparam int PROD_W         = 36;
  localparam int ACC_W          = 38;
  localparam int RATIO_Q        = 12;
  localparam int DIV5_MUL       = 52429;
  localparam int DIV5_SHIFT     = 18;
  localparam int V_MAX          = 1023 * 256;
  localparam int ADDR_W         = 4;
  localparam int DATA_W         = 32;

  localparam logic [2:0] ORDER_BGGR = 3'd1;
  localparam logic [2:0] ORDER_RGGB = 3'd2;
  localparam logic [2:0] ORDER_GBRG = 3'd3;
  localparam logic [2:0] ORDER_GRBG = 3'd4;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_BAYER_ORDER  = 2'd2,
    REG_BLACK_LEVEL  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0]  frame_width;
    logic [DIM_W-1:0]  frame_height;
    logic [2:0]        bayer_order;
    logic [PIX_W-1:0]  black_level;
    logic [ZDIM_W-1:0] zone_w;
    logic [ZDIM_W-1:0] zone_h;
  } cfg_t;

  function automatic logic [1:0] src_channel(input logic [2:0] order, input logic [1:0] k);
    logic [1:0] j;
    j = k;
    case (order)
      ORDER_BGGR: j = k ^ 2'd3;
      ORDER_RGGB: j = k;
      ORDER_GBRG: j = k ^ 2'd2;
      ORDER_GRBG: j = k ^ 2'd1;
      default:    j = k;
    endcase
    return j;
  endfunction

  function automatic logic [15:0] luma_weight(input logic [1:0] k);
    logic [15:0] w;
    case (k)
      2'd0:    w = 16'd19595;
      2'd1:    w = 16'd19235;
      2'd2:    w = 16'd19235;
      default: w = 16'd7471;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/bzs_cfg_regs.sv =====
// Configuration register file with its bus port and the derived zone dimensions.
`default_nettype none
module bzs_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bzs_pkg::ADDR_W-1:0]  paddr,
  input  logic [bzs_pkg::DATA_W-1:0]  pwdata,
  output logic [bzs_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output bzs_pkg::cfg_t               cfg
);
  import bzs_pkg::*;

  logic [DIM_W-1:0]  frame_width_r;
  logic [DIM_W-1:0]  frame_height_r;
  logic [2:0]        bayer_order_r;
  logic [PIX_W-1:0]  black_level_r;
  logic [ZDIM_W-1:0] zone_w_r;
  logic [ZDIM_W-1:0] zone_h_r;
  logic [28:0]       w_mul;
  logic [28:0]       h_mul;
  reg_idx_t          idx;
  logic              wr;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign w_mul  = 29'(frame_width_r) * 29'(DIV5_MUL);
  assign h_mul  = 29'(frame_height_r) * 29'(DIV5_MUL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= DIM_W'(4000);
      frame_height_r <= DIM_W'(3000);
      bayer_order_r  <= ORDER_RGGB;
      black_level_r  <= PIX_W'(64);
      zone_w_r       <= ZDIM_W'(800);
      zone_h_r       <= ZDIM_W'(600);
    end else begin
      zone_w_r <= w_mul[DIV5_SHIFT+ZDIM_W-1:DIV5_SHIFT];
      zone_h_r <= h_mul[DIV5_SHIFT+ZDIM_W-1:DIV5_SHIFT];
      if (wr) begin
        unique case (idx)
          REG_FRAME_WIDTH:  frame_width_r  <= pwdata[DIM_W-1:0];
          REG_FRAME_HEIGHT: frame_height_r <= pwdata[DIM_W-1:0];
          REG_BAYER_ORDER:  bayer_order_r  <= pwdata[2:0];
          REG_BLACK_LEVEL:  black_level_r  <= pwdata[PIX_W-1:0];
          default:          ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (idx)
      REG_FRAME_WIDTH:  prdata = DATA_W'(frame_width_r);
      REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height_r);
      REG_BAYER_ORDER:  prdata = DATA_W'(bayer_order_r);
      REG_BLACK_LEVEL:  prdata = DATA_W'(black_level_r);
      default:          prdata = '0;
    endcase
  end

  assign cfg.frame_width  = frame_width_r;
  assign cfg.frame_height = frame_height_r;
  assign cfg.bayer_order  = bayer_order_r;
  assign cfg.black_level  = black_level_r;
  assign cfg.zone_w       = zone_w_r;
  assign cfg.zone_h       = zone_h_r;

endmodule
`default_nettype wire

// ===== rtl/bzs_divider.sv =====
// Shared restoring divider that produces one quotient bit per cycle.
`default_nettype none
module bzs_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [bzs_pkg::NUM_W-1:0]  num,
  input  logic [bzs_pkg::CNT_W-1:0]  den,
  output logic [bzs_pkg::NUM_W-1:0]  quot,
  output logic                       done
);
  import bzs_pkg::*;

  localparam int STEP_W = $clog2(NUM_W);

  logic [NUM_W-1:0]  quo_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  den_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [CNT_W:0]    trial;
  logic              ge;
  logic [CNT_W-1:0]  rem_nxt;

  assign trial   = {rem_r, quo_r[NUM_W-1]};
  assign ge      = trial >= {1'b0, den_r};
  assign rem_nxt = ge ? CNT_W'(trial - {1'b0, den_r}) : trial[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r  <= num;
        rem_r  <= '0;
        den_r  <= den;
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        rem_r  <= rem_nxt;
        quo_r  <= {quo_r[NUM_W-2:0], ge};
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quot = quo_r;
  assign done = done_r;

endmodule
`default_nettype wire

// ===== rtl/bayer_zone_shading_stats.sv =====
// Top level of the Bayer zone shading statistics block: pixel accumulation and frame-end sequencer.
// Each pixel word is accepted, then read and written back in the zone sum memory before the next is taken.
// After the last pixel of a frame the sequencer works zone by zone through four channel
// averages on the shared 41-step divider and one multiplier, then computes each ratio
// on the same divider unless the centre luma is zero, emits one result word at a time and
// waits out any output stall. A clearing pass over all 100 words of the sum memory follows
// reset and every frame; no pixel is accepted during it or during frame-end work.
`default_nettype none
module bayer_zone_shading_stats (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bzs_pkg::PIX_W-1:0]         in_pixel,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bzs_pkg::ZONE_W-1:0]        out_zone_index,
  output logic signed [14:0]                out_zone_luma,
  output logic signed [15:0]                out_zone_ratio,
  output logic [15:0]                       out_spread,
  output logic                              out_last,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bzs_pkg::ADDR_W-1:0]        paddr,
  input  logic [bzs_pkg::DATA_W-1:0]        pwdata,
  output logic [bzs_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);
  import bzs_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_PRD, S_PWR, S_LRD, S_LDIV, S_LWAIT, S_LMUL, S_LACC, S_LFIN,
    S_EDIV, S_EWAIT, S_ESAT, S_EOUT
  } state_t;

  cfg_t cfg;

  bzs_cfg_regs u_cfg (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  state_t               state_r;
  logic [MEM_AW-1:0]    clr_cnt_r;
  logic [DIM_W-1:0]     col_r, row_r, px_col_r, px_row_r;
  logic [PIX_W-1:0]     pix_r;
  logic                 eof_r;
  logic [MEM_AW-1:0]    pa_r;
  logic                 pin_r;
  logic [ZONE_W-1:0]    zone_r;
  logic [1:0]           k_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [NUM_W-1:0]     avg_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [LUMA_W-1:0] lc_r;
  logic signed [LUMA_W-1:0] luma_store_r [NZONES];
  logic [2:0]           er_r, ec_r;
  logic                 neg_r, lcz_r;
  logic signed [17:0]   mx_r, mn_r;
  logic                 out_valid_r;
  logic [ZONE_W-1:0]    out_zone_index_r;
  logic signed [14:0]   out_zone_luma_r;
  logic signed [15:0]   out_zone_ratio_r;
  logic [15:0]          out_spread_r;
  logic                 out_last_r;

  logic [SUM_W-1:0] sum_mem [MEM_DEPTH];
  logic [SUM_W-1:0] rd_r;
  logic             mem_we, mem_re;
  logic [MEM_AW-1:0] mem_wa, mem_ra;
  logic [SUM_W-1:0] mem_wd;

  // Raster position
  logic line_end, frame_end, accept;
  assign accept    = in_valid && (state_r == S_IDLE);
  assign line_end  = ({1'b0, col_r} + 14'd1) >= {1'b0, cfg.frame_width};
  assign frame_end = line_end && (({1'b0, row_r} + 14'd1) >= {1'b0, cfg.frame_height});

  // Zone and channel of the latched pixel
  logic [13:0] zw1, zw2, zw3, zw4, zw5, zh1, zh2, zh3, zh4, zh5;
  logic        gx1, gx2, gx3, gx4, gx5, gy1, gy2, gy3, gy4, gy5;
  logic [2:0]  zc, zr;
  logic        px_in;
  logic [1:0]  px_ch;
  logic [ZONE_W-1:0] px_zone;

  assign zw1 = 14'(cfg.zone_w);
  assign zw2 = zw1 << 1;
  assign zw3 = zw2 + zw1;
  assign zw4 = zw1 << 2;
  assign zw5 = zw4 + zw1;
  assign zh1 = 14'(cfg.zone_h);
  assign zh2 = zh1 << 1;
  assign zh3 = zh2 + zh1;
  assign zh4 = zh1 << 2;
  assign zh5 = zh4 + zh1;
  assign gx1 = {1'b0, px_col_r} >= zw1;
  assign gx2 = {1'b0, px_col_r} >= zw2;
  assign gx3 = {1'b0, px_col_r} >= zw3;
  assign gx4 = {1'b0, px_col_r} >= zw4;
  assign gx5 = {1'b0, px_col_r} >= zw5;
  assign gy1 = {1'b0, px_row_r} >= zh1;
  assign gy2 = {1'b0, px_row_r} >= zh2;
  assign gy3 = {1'b0, px_row_r} >= zh3;
  assign gy4 = {1'b0, px_row_r} >= zh4;
  assign gy5 = {1'b0, px_row_r} >= zh5;
  assign zc = {2'b0, gx1} + {2'b0, gx2} + {2'b0, gx3} + {2'b0, gx4};
  assign zr = {2'b0, gy1} + {2'b0, gy2} + {2'b0, gy3} + {2'b0, gy4};
  assign px_in = (cfg.zone_w != '0) && (cfg.zone_h != '0) && !gx5 && !gy5;
  assign px_ch = {px_row_r[0] ^ (zr[0] & cfg.zone_h[0]),
                  px_col_r[0] ^ (zc[0] & cfg.zone_w[0])};
  assign px_zone = ({2'b0, zr} << 2) + {2'b0, zr} + {2'b0, zc};

  // Channel counts and luma sequencing
  logic [1:0]        lj;
  logic [HALF_W-1:0] cr, cc;
  logic              order_ok;
  assign lj = src_channel(cfg.bayer_order, k_r);
  assign cr = lj[1] ? HALF_W'(cfg.zone_h >> 1) : HALF_W'((12'(cfg.zone_h) + 12'd1) >> 1);
  assign cc = lj[0] ? HALF_W'(cfg.zone_w >> 1) : HALF_W'((12'(cfg.zone_w) + 12'd1) >> 1);
  assign order_ok = (cfg.bayer_order >= ORDER_BGGR) && (cfg.bayer_order <= ORDER_GRBG);

  logic signed [41:0]    a_full;
  logic signed [V_W-1:0] v;
  logic signed [ACC_W-1:0] lsum;
  assign a_full = $signed({1'b0, avg_r}) - $signed({24'b0, cfg.black_level, 8'b0});
  assign v      = (a_full > 42'(V_MAX)) ? V_W'(V_MAX) : a_full[V_W-1:0];
  assign lsum   = acc_r + ACC_W'(1 << (LUMA_SHIFT - 1));

  // Emit side
  logic [2:0]              rowf;
  logic [ZONE_W-1:0]       src;
  logic signed [LUMA_W-1:0] li;
  logic [LUMA_W-1:0]       ali, alc;
  logic                    elast;
  assign rowf  = 3'(GRID - 1) - er_r;
  assign src   = ({2'b0, rowf} << 2) + {2'b0, rowf} + {2'b0, ec_r};
  assign li    = luma_store_r[src];
  assign ali   = li[LUMA_W-1] ? LUMA_W'(-li) : LUMA_W'(li);
  assign alc   = lc_r[LUMA_W-1] ? LUMA_W'(-lc_r) : LUMA_W'(lc_r);
  assign elast = (er_r == 3'(GRID - 1)) && (ec_r == 3'(GRID - 1));

  // Shared divider
  logic             div_start, div_done;
  logic [NUM_W-1:0] div_num, div_quot;
  logic [CNT_W-1:0] div_den;
  always_comb begin
    if (state_r == S_LDIV) begin
      div_start = order_ok && (cnt_r != '0);
      div_num   = {1'b0, rd_r, 8'b0} + NUM_W'(cnt_r >> 1);
      div_den   = cnt_r;
    end else begin
      div_start = (state_r == S_EDIV) && (lc_r != '0);
      div_num   = NUM_W'({ali, 12'b0}) + NUM_W'(alc >> 1);
      div_den   = CNT_W'(alc);
    end
  end

  bzs_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .quot(div_quot), .done(div_done)
  );

  // Ratio, saturation and spread
  logic signed [16:0] rat;
  logic signed [17:0] rat18, mx_n, mn_n;
  logic signed [18:0] sp;
  logic [15:0]        sp_sat;
  always_comb begin
    if (lcz_r) begin
      rat = '0;
    end else if (neg_r) begin
      rat = (div_quot > NUM_W'(32768)) ? -17'sd32768 : -$signed(div_quot[16:0]);
    end else begin
      rat = (div_quot > NUM_W'(32767)) ? 17'sd32767 : $signed(div_quot[16:0]);
    end
    rat18  = 18'(rat);
    mx_n   = (rat18 > mx_r) ? rat18 : mx_r;
    mn_n   = (rat18 < mn_r) ? rat18 : mn_r;
    sp     = 19'(mx_n) - 19'(mn_n);
    sp_sat = sp[18] ? 16'd0 : ((sp > 19'sd65535) ? 16'hFFFF : sp[15:0]);
  end

  // Sum memory ports
  always_comb begin
    mem_we = 1'b0;
    mem_wa = pa_r;
    mem_wd = rd_r + SUM_W'(pix_r);
    mem_re = 1'b0;
    mem_ra = {px_zone, px_ch};
    unique case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt_r;
        mem_wd = '0;
      end
      S_PRD: mem_re = 1'b1;
      S_PWR: mem_we = pin_r;
      S_LRD: begin
        mem_re = 1'b1;
        mem_ra = {zone_r, lj};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) sum_mem[mem_wa] <= mem_wd;
    if (mem_re) rd_r <= sum_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + MEM_AW'(1);
          if (clr_cnt_r == MEM_AW'(MEM_DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            pix_r    <= in_pixel;
            px_col_r <= col_r;
            px_row_r <= row_r;
            eof_r    <= frame_end;
            col_r    <= line_end ? '0 : col_r + DIM_W'(1);
            if (line_end) row_r <= frame_end ? '0 : row_r + DIM_W'(1);
            state_r  <= S_PRD;
          end
        end
        S_PRD: begin
          pa_r    <= {px_zone, px_ch};
          pin_r   <= px_in;
          state_r <= S_PWR;
        end
        S_PWR: begin
          zone_r  <= '0;
          k_r     <= '0;
          acc_r   <= '0;
          state_r <= eof_r ? S_LRD : S_IDLE;
        end
        S_LRD: begin
          cnt_r   <= CNT_W'(cr) * CNT_W'(cc);
          state_r <= S_LDIV;
        end
        S_LDIV: begin
          avg_r   <= '0;
          state_r <= div_start ? S_LWAIT : S_LMUL;
        end
        S_LWAIT: begin
          if (div_done) begin
            avg_r   <= div_quot;
            state_r <= S_LMUL;
          end
        end
        S_LMUL: begin
          prod_r  <= PROD_W'(v) * PROD_W'($signed({1'b0, luma_weight(k_r)}));
          state_r <= S_LACC;
        end
        S_LACC: begin
          acc_r   <= acc_r + ACC_W'(prod_r);
          k_r     <= k_r + 2'd1;
          state_r <= (k_r == 2'd3) ? S_LFIN : S_LRD;
        end
        S_LFIN: begin
          luma_store_r[zone_r] <= lsum[LUMA_SHIFT+LUMA_W-1:LUMA_SHIFT];
          if (zone_r == ZONE_W'(CENTER)) lc_r <= lsum[LUMA_SHIFT+LUMA_W-1:LUMA_SHIFT];
          acc_r <= '0;
          if (zone_r == ZONE_W'(NZONES - 1)) begin
            er_r    <= '0;
            ec_r    <= '0;
            mx_r    <= '0;
            mn_r    <= 18'sd65536;
            state_r <= S_EDIV;
          end else begin
            zone_r  <= zone_r + ZONE_W'(1);
            state_r <= S_LRD;
          end
        end
        S_EDIV: begin
          lcz_r   <= (lc_r == '0);
          neg_r   <= li[LUMA_W-1] != lc_r[LUMA_W-1];
          state_r <= div_start ? S_EWAIT : S_ESAT;
        end
        S_EWAIT: begin
          if (div_done) state_r <= S_ESAT;
        end
        S_ESAT: begin
          mx_r             <= mx_n;
          mn_r             <= mn_n;
          out_valid_r      <= 1'b1;
          out_zone_index_r <= ZONE_W'(({2'b0, er_r} << 2) + {2'b0, er_r} + {2'b0, ec_r});
          out_zone_luma_r  <= li[14:0];
          out_zone_ratio_r <= rat[15:0];
          out_spread_r     <= elast ? sp_sat : 16'd0;
          out_last_r       <= elast;
          state_r          <= S_EOUT;
        end
        S_EOUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (elast) begin
              clr_cnt_r <= '0;
              state_r   <= S_CLR;
            end else begin
              if (ec_r == 3'(GRID - 1)) begin
                ec_r <= '0;
                er_r <= er_r + 3'd1;
              end else begin
                ec_r <= ec_r + 3'd1;
              end
              state_r <= S_EDIV;
            end
          end
        end
        default: state_r <= S_CLR;
      endcase
    end
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_zone_index = out_zone_index_r;
  assign out_zone_luma  = out_zone_luma_r;
  assign out_zone_ratio = out_zone_ratio_r;
  assign out_spread     = out_spread_r;
  assign out_last       = out_last_r;

endmodule
`default_nettype wire
